// ===== rtl/core/csq_pkg.sv =====
`timescale 1ns / 1ps
package csq_pkg;
    localparam int WAIT_DEPTH = 16;
    localparam int KEY_WIDTH  = 16;
    localparam int IDX_W      = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CNT_W      = $clog2(WAIT_DEPTH + 1);
    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = 1;

    localparam logic [1:0] OP_TRY    = 2'd0;
    localparam logic [1:0] OP_TAKE   = 2'd1;
    localparam logic [1:0] OP_GIVE   = 2'd2;
    localparam logic [1:0] OP_CANCEL = 2'd3;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_FULL = 2'd1;
    localparam logic [1:0] ERR_SAT  = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  requester;
        logic [15:0] keys;
    } req_t;
endpackage

// ===== rtl/core/csq_front.sv =====
`timescale 1ns / 1ps
// Input skid queue: accepts requests while the back end is busy.
module csq_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  csq_pkg::req_t   in_req,
    output logic            q_valid,
    input  logic            q_ready,
    output csq_pkg::req_t   q_req
);
    csq_pkg::req_t mem_reg [csq_pkg::FIFO_DEPTH];
    logic [csq_pkg::FPTR_W-1:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready = (cnt_reg != 2'(csq_pkg::FIFO_DEPTH));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty");
endmodule

// ===== rtl/core/csq_back.sv =====
`timescale 1ns / 1ps
// Executes one request: reply, wake scan after a give-back, sweep for a cancel.
// One list entry per cycle unless a wake stalls; removal shifts the tail down.
module csq_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [15:0]     cfg_wdata,
    input  logic            q_valid,
    output logic            q_ready,
    input  csq_pkg::req_t   q_req,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            kind,
    output logic [7:0]      who,
    output logic            granted,
    output logic            waiting,
    output logic [1:0]      error,
    output logic [15:0]     keys_left,
    output logic            last
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_CANC = 2'd2;
    localparam int KW    = csq_pkg::KEY_WIDTH;
    localparam int IW    = csq_pkg::IDX_W;
    localparam int CW    = csq_pkg::CNT_W;
    localparam int DEPTH = csq_pkg::WAIT_DEPTH;
    localparam int XW    = (KW > 16) ? KW : 16;   // compare width

    logic [7:0]    wwho_reg  [DEPTH];
    logic [15:0]   wkeys_reg [DEPTH];
    logic [CW-1:0] used_reg, used_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic [1:0]    st_reg, st_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [7:0]    creq_reg, creq_next;
    // pending result: held until it is known whether another one follows
    logic          pkind_reg, pkind_next;
    logic [7:0]    pwho_reg, pwho_next;
    logic [1:0]    perr_reg, perr_next;
    logic [15:0]   pkl_reg, pkl_next;
    // output register
    logic          ov_reg, ov_next;
    logic          okind_reg, okind_next, ogr_reg, ogr_next, owt_reg, owt_next;
    logic          olast_reg, olast_next;
    logic [7:0]    owho_reg, owho_next;
    logic [1:0]    oerr_reg, oerr_next;
    logic [15:0]   okl_reg, okl_next;
    logic          app_we, rm_we, flush, flush_last;
    logic          ovfree, at_end, fits_q, fits_e;
    logic [7:0]    ewho;
    logic [15:0]   ekeys;
    logic [XW-1:0] x_cnt, x_qkeys, x_ekeys;
    logic [XW:0]   sum, key_max;

    assign ovfree  = !ov_reg || out_ready;
    assign q_ready = (st_reg == S_IDLE) && ovfree;
    assign at_end  = (rd_reg == used_reg);
    assign ewho    = wwho_reg[rd_reg[IW-1:0]];
    assign ekeys   = wkeys_reg[rd_reg[IW-1:0]];
    assign x_cnt   = XW'(cnt_reg);
    assign x_qkeys = XW'(q_req.keys);
    assign x_ekeys = XW'(ekeys);
    assign fits_q  = (x_cnt >= x_qkeys);
    assign fits_e  = (x_cnt >= x_ekeys);
    assign sum     = {1'b0, x_cnt} + {1'b0, x_qkeys};
    assign key_max = {{(XW + 1 - KW){1'b0}}, {KW{1'b1}}};

    always_comb
    begin
        used_next  = used_reg;
        cnt_next   = cnt_reg;
        st_next    = st_reg;
        rd_next    = rd_reg;
        creq_next  = creq_reg;
        pkind_next = pkind_reg;
        pwho_next  = pwho_reg;
        perr_next  = perr_reg;
        pkl_next   = pkl_reg;
        ov_next    = ov_reg && !out_ready;
        okind_next = okind_reg;
        owho_next  = owho_reg;
        ogr_next   = ogr_reg;
        owt_next   = owt_reg;
        oerr_next  = oerr_reg;
        okl_next   = okl_reg;
        olast_next = olast_reg;
        app_we     = 1'b0;
        rm_we      = 1'b0;
        flush      = 1'b0;
        flush_last = 1'b0;
        case (st_reg)
            S_IDLE:
            begin
                if (q_valid && q_ready)
                begin
                    creq_next  = q_req.requester;
                    rd_next    = '0;
                    pkind_next = 1'b0;
                    pwho_next  = q_req.requester;
                    perr_next  = csq_pkg::ERR_NONE;
                    case (q_req.op)
                        csq_pkg::OP_TRY, csq_pkg::OP_TAKE:
                        begin
                            // single result, straight to the output register
                            ov_next    = 1'b1;
                            okind_next = 1'b0;
                            owho_next  = q_req.requester;
                            ogr_next   = 1'b0;
                            owt_next   = 1'b0;
                            oerr_next  = csq_pkg::ERR_NONE;
                            olast_next = 1'b1;
                            if (fits_q)
                            begin
                                cnt_next = KW'(x_cnt - x_qkeys);
                                ogr_next = 1'b1;
                            end
                            else if (q_req.op == csq_pkg::OP_TAKE)
                            begin
                                if (used_reg < CW'(DEPTH))
                                begin
                                    app_we    = 1'b1;
                                    used_next = used_reg + 1'b1;
                                    owt_next  = 1'b1;
                                end
                                else
                                begin
                                    oerr_next = csq_pkg::ERR_FULL;
                                end
                            end
                            okl_next = 16'(cnt_next);
                        end
                        csq_pkg::OP_GIVE:
                        begin
                            if (sum > key_max)
                            begin
                                cnt_next  = '1;
                                perr_next = csq_pkg::ERR_SAT;
                            end
                            else
                            begin
                                cnt_next = KW'(sum);
                            end
                            pkl_next = 16'(cnt_next);
                            st_next  = S_SCAN;
                        end
                        default:
                        begin
                            pkl_next = 16'(cnt_reg);
                            st_next  = S_CANC;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (at_end)
                begin
                    if (ovfree)
                    begin
                        flush      = 1'b1;
                        flush_last = 1'b1;
                        st_next    = S_IDLE;
                    end
                end
                else if (fits_e)
                begin
                    // earlier entries did not fit a larger count, so the
                    // scan goes on at the same slot after the removal
                    if (ovfree)
                    begin
                        flush      = 1'b1;
                        cnt_next   = KW'(x_cnt - x_ekeys);
                        rm_we      = 1'b1;
                        used_next  = used_reg - 1'b1;
                        pkind_next = 1'b1;
                        pwho_next  = ewho;
                        perr_next  = csq_pkg::ERR_NONE;
                        pkl_next   = 16'(cnt_next);
                    end
                end
                else
                begin
                    rd_next = rd_reg + 1'b1;
                end
            end
            S_CANC:
            begin
                if (at_end)
                begin
                    if (ovfree)
                    begin
                        flush      = 1'b1;
                        flush_last = 1'b1;
                        st_next    = S_IDLE;
                    end
                end
                else if (ewho == creq_reg)
                begin
                    rm_we     = 1'b1;
                    used_next = used_reg - 1'b1;
                end
                else
                begin
                    rd_next = rd_reg + 1'b1;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
        if (flush)
        begin
            ov_next    = 1'b1;
            okind_next = pkind_reg;
            owho_next  = pwho_reg;
            ogr_next   = pkind_reg;
            owt_next   = 1'b0;
            oerr_next  = perr_reg;
            okl_next   = pkl_reg;
            olast_next = flush_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (app_we)
        begin
            wwho_reg[used_reg[IW-1:0]]  <= q_req.requester;
            wkeys_reg[used_reg[IW-1:0]] <= q_req.keys;
        end
        for (int j = 0; j < DEPTH - 1; j++)
        begin
            if (rm_we && CW'(j) >= rd_reg)
            begin
                wwho_reg[j]  <= wwho_reg[j + 1];
                wkeys_reg[j] <= wkeys_reg[j + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0; cnt_reg <= '0; st_reg <= S_IDLE; ov_reg <= 1'b0;
            rd_reg <= '0;
        end
        else
        begin
            used_reg <= used_next; st_reg <= st_next; ov_reg <= ov_next;
            rd_reg <= rd_next;
            cnt_reg <= cfg_we ? KW'(cfg_wdata) : cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        creq_reg <= creq_next; pkind_reg <= pkind_next; pwho_reg <= pwho_next;
        perr_reg <= perr_next; pkl_reg <= pkl_next;
        okind_reg <= okind_next; owho_reg <= owho_next;
        ogr_reg <= ogr_next; owt_reg <= owt_next; oerr_reg <= oerr_next;
        okl_reg <= okl_next; olast_reg <= olast_next;
    end

    assign out_valid = ov_reg;
    assign kind = okind_reg; assign who = owho_reg; assign granted = ogr_reg;
    assign waiting = owt_reg; assign error = oerr_reg;
    assign keys_left = okl_reg; assign last = olast_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(DEPTH)) else $error("wait list overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_reg <= used_reg) else $error("scan past fill");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind) |-> (granted && !waiting && error == csq_pkg::ERR_NONE))
        else $error("bad wake fields");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(who) && $stable(keys_left)))
        else $error("result changed while stalled");
endmodule

// ===== rtl/core/counting_semaphore_waiter_queue.sv =====
`timescale 1ns / 1ps
// Channel  | handshake             | payload
// request  | in_valid / in_ready   | op, requester, keys
// result   | out_valid / out_ready | kind, who, granted, waiting, error, keys_left, last
// config   | cfg_we                | cfg_wdata (initial_keys)
// A request enters a two-entry queue; the back end takes it once idle with a free output register.
// Try-take and take: one result, written straight into the output register.
// Give-back and cancel: one wait-list entry per cycle, save where a wake waits for
// out_ready; the final result (last set) comes when the walk reaches the list fill.
// Reset clears key count and list fill; out_ready low holds the back end at
// its next result, and in_ready drops once the queue holds two requests.
module counting_semaphore_waiter_queue
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  requester,
    input  logic [15:0] keys,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  who,
    output logic        granted,
    output logic        waiting,
    output logic [1:0]  error,
    output logic [15:0] keys_left,
    output logic        last
);
    csq_pkg::req_t in_req, q_req;
    logic q_valid, q_ready;

    assign in_req = '{op: op, requester: requester, keys: keys};

    csq_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    csq_back u_back
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .who(who),
        .granted(granted), .waiting(waiting), .error(error),
        .keys_left(keys_left), .last(last)
    );
endmodule

// ===== tb/tb_counting_semaphore_waiter_queue.sv =====
`timescale 1ns / 1ps
module tb_counting_semaphore_waiter_queue;

    typedef struct {
        logic        kind;
        logic [7:0]  who;
        logic        granted;
        logic        waiting;
        logic [1:0]  error;
        logic [15:0] keys_left;
        logic        last;
    } sem_result_t;

    // Semaphore shadow: key count, ordered waiter list, and the queue of
    // results that the block still owes.
    class sem_scoreboard;
        logic [15:0] key_count;
        logic [7:0]  wl_who[$];
        logic [15:0] wl_keys[$];
        sem_result_t owed[$];
        int          errors;

        function new();
            key_count = '0;
            errors    = 0;
        endfunction

        function void load_keys(logic [15:0] v);
            key_count = v;
        endfunction

        function void push_result(logic k, logic [7:0] w, logic g, logic wt,
                                  logic [1:0] e);
            sem_result_t r;
            r.kind = k; r.who = w; r.granted = g; r.waiting = wt;
            r.error = e; r.keys_left = key_count; r.last = 1'b0;
            owed.insert(owed.size(), r);
        endfunction

        function void note_request(logic [1:0] o, logic [7:0] rq, logic [15:0] kk);
            int unsigned sum;
            bit          hit;
            logic [1:0]  e;
            case (o)
                csq_pkg::OP_TRY:
                begin
                    hit = key_count >= kk;
                    if (hit) key_count -= kk;
                    push_result(1'b0, rq, hit, 1'b0, csq_pkg::ERR_NONE);
                end
                csq_pkg::OP_TAKE:
                begin
                    if (key_count >= kk)
                    begin
                        key_count -= kk;
                        push_result(1'b0, rq, 1'b1, 1'b0, csq_pkg::ERR_NONE);
                    end
                    else if (wl_who.size() < csq_pkg::WAIT_DEPTH)
                    begin
                        wl_who.insert(wl_who.size(), rq);
                        wl_keys.insert(wl_keys.size(), kk);
                        push_result(1'b0, rq, 1'b0, 1'b1, csq_pkg::ERR_NONE);
                    end
                    else
                        push_result(1'b0, rq, 1'b0, 1'b0, csq_pkg::ERR_FULL);
                end
                csq_pkg::OP_GIVE:
                begin
                    sum = key_count + kk;
                    e = csq_pkg::ERR_NONE;
                    if (sum > 16'hFFFF)
                    begin
                        sum = 16'hFFFF;
                        e = csq_pkg::ERR_SAT;
                    end
                    key_count = sum[15:0];
                    push_result(1'b0, rq, 1'b0, 1'b0, e);
                    // wake first fitting waiter, rescan from head each time
                    hit = 1;
                    while (hit)
                    begin
                        hit = 0;
                        for (int i = 0; i < wl_who.size() && !hit; i++)
                            if (key_count >= wl_keys[i])
                            begin
                                key_count -= wl_keys[i];
                                push_result(1'b1, wl_who[i], 1'b1, 1'b0,
                                            csq_pkg::ERR_NONE);
                                wl_who.delete(i);
                                wl_keys.delete(i);
                                hit = 1;
                            end
                    end
                end
                default:
                begin
                    for (int i = wl_who.size() - 1; i >= 0; i--)
                        if (wl_who[i] == rq)
                        begin
                            wl_who.delete(i);
                            wl_keys.delete(i);
                        end
                    push_result(1'b0, rq, 1'b0, 1'b0, csq_pkg::ERR_NONE);
                end
            endcase
            owed[owed.size() - 1].last = 1'b1;
        endfunction

        function void check_result(sem_result_t a);
            sem_result_t x;
            if (owed.size() == 0)
            begin
                $error("unexpected result who=%0d", a.who);
                errors++;
                return;
            end
            x = owed[0];
            owed.delete(0);
            if (a.kind !== x.kind)
                begin $error("kind exp %0d got %0d", x.kind, a.kind); errors++; end
            if (a.who !== x.who)
                begin $error("who exp %0d got %0d", x.who, a.who); errors++; end
            if (a.granted !== x.granted)
                begin $error("granted exp %0d got %0d", x.granted, a.granted); errors++; end
            if (a.waiting !== x.waiting)
                begin $error("waiting exp %0d got %0d", x.waiting, a.waiting); errors++; end
            if (a.error !== x.error)
                begin $error("error exp %0d got %0d", x.error, a.error); errors++; end
            if (a.keys_left !== x.keys_left)
                begin $error("keys_left exp %0d got %0d", x.keys_left, a.keys_left); errors++; end
            if (a.last !== x.last)
                begin $error("last exp %0d got %0d", x.last, a.last); errors++; end
        endfunction
    endclass

    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [7:0]  requester;
    logic [15:0] keys;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic [7:0]  who;
    logic        granted;
    logic        waiting;
    logic [1:0]  error;
    logic [15:0] keys_left;
    logic        last;

    sem_scoreboard sb;
    int            idle_cycles;
    bit            no_gaps;   // phases with back-to-back requests and results

    counting_semaphore_waiter_queue dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .requester (requester),
        .keys      (keys),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .who       (who),
        .granted   (granted),
        .waiting   (waiting),
        .error     (error),
        .keys_left (keys_left),
        .last      (last)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Result side: sample on the rising edge, change ready on the falling one.
    always @(posedge clk)
    begin
        sem_result_t r;
        if (rst_n && out_valid && out_ready)
        begin
            r.kind = kind; r.who = who; r.granted = granted; r.waiting = waiting;
            r.error = error; r.keys_left = keys_left; r.last = last;
            sb.check_result(r);
        end
    end

    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 16);
            @(negedge clk);
            out_ready = (gap == 0);
            while (gap > 0)
            begin
                @(negedge clk);
                gap--;
                if (gap == 0) out_ready = 1'b1;
            end
            // hold ready until one result is taken
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // Watchdog: cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && (in_valid || sb.owed.size() != 0))
        begin
            $display("** counting_semaphore_waiter_queue: FAILED **");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] o, logic [7:0] rq, logic [15:0] kk);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        repeat (gap) @(negedge clk);
        op = o;
        requester = rq;
        keys = kk;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_request(o, rq, kk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Idle write: wait for every owed result, then let the back end settle.
    task automatic write_initial_keys(logic [15:0] v);
        while (sb.owed.size() != 0) @(negedge clk);
        repeat (2 * csq_pkg::WAIT_DEPTH + 8) @(negedge clk);
        cfg_wdata = v;
        cfg_we = 1'b1;
        @(negedge clk);
        sb.load_keys(v);
        cfg_we = 1'b0;
    endtask

    // Random key amount: mostly small so waiters wake, sometimes extreme.
    function automatic logic [15:0] pick_keys();
        case ($urandom_range(0, 9))
            0: return 16'hFFFF;
            1: return 16'($urandom);
            2: return 16'h0;
            default: return 16'($urandom_range(0, 40));
        endcase
    endfunction

    initial
    begin
        logic [1:0] o;
        sb = new();
        no_gaps = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        op = csq_pkg::OP_TRY;
        requester = '0;
        keys = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty semaphore, zero-key takes, wait-list fill and overflow,
        // give-back up to the key maximum that wakes waiters, cancels present and absent.
        send_request(csq_pkg::OP_TRY, 8'h00, 16'h0000);
        send_request(csq_pkg::OP_TRY, 8'hFF, 16'h0001);
        send_request(csq_pkg::OP_TAKE, 8'hAA, 16'h0000);
        for (int i = 0; i < csq_pkg::WAIT_DEPTH + 1; i++)
            send_request(csq_pkg::OP_TAKE, 8'(i * 17),
                         (i == 3) ? 16'hFFFF : 16'(i + 1));
        send_request(csq_pkg::OP_CANCEL, 8'(2 * 17), 16'h5555);
        send_request(csq_pkg::OP_CANCEL, 8'h77, 16'h0000);
        send_request(csq_pkg::OP_GIVE, 8'h55, 16'hFFFF);
        send_request(csq_pkg::OP_GIVE, 8'hAA, 16'h0000);
        send_request(csq_pkg::OP_CANCEL, 8'(3 * 17), 16'hFFFF);

        write_initial_keys(16'hFFFF);
        send_request(csq_pkg::OP_GIVE, 8'h01, 16'h0001);
        send_request(csq_pkg::OP_TRY, 8'h02, 16'hFFFF);
        write_initial_keys(16'h0000);

        // Random phases; the preset is rewritten after each phase, and two phases run without gaps.
        for (int ph = 0; ph < 6; ph++)
        begin
            no_gaps = (ph == 2 || ph == 4);
            for (int n = 0; n < 36; n++)
            begin
                o = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0) o = csq_pkg::OP_GIVE;
                send_request(o, 8'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 5)),
                             pick_keys());
            end
            case (ph)
                0: write_initial_keys(16'h0005);
                1: write_initial_keys(16'hFFFF);
                2: write_initial_keys(16'($urandom));
                3: write_initial_keys(16'h0000);
                default: write_initial_keys(16'h0100);
            endcase
        end
        no_gaps = 0;

        while (sb.owed.size() != 0) @(negedge clk);
        repeat (4 * csq_pkg::WAIT_DEPTH + 20) @(negedge clk);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("** counting_semaphore_waiter_queue: PASSED **");
        else
            $display("** counting_semaphore_waiter_queue: FAILED **");
        $finish;
    end
endmodule
